[src/bssc_pkg.sv]
// shared constants for the bounded step sequence counter
package bssc_pkg;

  // field widths
  localparam int unsigned ValueWidth = 8;
  localparam int unsigned CountWidth = 30;

  // default depth of the per-value count store
  localparam int unsigned DefaultMaxValue = 128;

  // bound register value after reset
  localparam logic [ValueWidth-1:0] UpperReset = 8'd128;

  // counts are kept modulo this prime
  localparam logic [CountWidth-1:0] Modulus = 30'd1000000007;

endpackage

[src/bssc_in_if.sv]
// request channel carrying one sequence position
interface bssc_in_if;
  import bssc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] position_value;
  logic                  is_last;

  modport source (output valid, output position_value, output is_last, input ready);
  modport sink   (input valid, input position_value, input is_last, output ready);
endinterface

[src/bssc_out_if.sv]
// result channel carrying the sequence count
interface bssc_out_if;
  import bssc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] sequence_count;

  modport source (output valid, output sequence_count, input ready);
  modport sink   (input valid, input sequence_count, output ready);
endinterface

[src/bounded_step_sequence_counter.sv]
// top level: counts bounded-step sequences position by position
//
// in_i takes one request per sequence position: position_value (0 = free,
// otherwise the fixed value) and is_last. out_o delivers one sequence_count
// (modulo 1000000007) for every request marked is_last and nothing otherwise.
// cfg_we_i/cfg_wdata_i write the upper_value bound; write it only while idle.
// Each request runs one pass over all MAX_VALUE counts held in a single-port
// read, single-port write memory, one count per cycle, through one shared
// three-term modular adder plus a modular accumulator for the final sum.
// A request is taken in an idle cycle and holds ready low through the run,
// drain and finish states of that pass; the next request is taken only once
// the block is idle again. The count of a last position is registered in the
// finish state and then held valid on out_o until it is taken.
// The result is registered: the block goes on taking requests while a result
// waits, and only stalls at the end of the next last position if out_o is
// still blocked then.
// Reset clears the control state, sets the bound to 128 and marks the next
// request as the start of a sequence; the count memory needs no clearing,
// since the first position of every sequence writes every entry.
module bounded_step_sequence_counter #(
  parameter int unsigned MAX_VALUE = bssc_pkg::DefaultMaxValue
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bssc_pkg::ValueWidth-1:0] cfg_wdata_i,
  bssc_in_if.sink                         in_i,
  bssc_out_if.source                      out_o
);
  import bssc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VALUE + 3);
  localparam int unsigned AW = $clog2(MAX_VALUE);
  localparam int unsigned XW = (CW > ValueWidth) ? CW : ValueWidth;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRun    = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  localparam logic [31:0] Mod1 = {2'b00, Modulus};
  localparam logic [31:0] Mod2 = {1'b0, Modulus, 1'b0};

  logic [ValueWidth-1:0] upper_q;
  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         step_q, step_d;
  logic [ValueWidth-1:0] fixed_q;
  logic                  last_q;
  logic                  start_q;
  logic [CountWidth-1:0] lo_q, mid_q, rd_q;
  logic [CountWidth-1:0] nv_q;
  logic                  nv_vld_q;
  logic [CountWidth-1:0] acc_q, acc_d;
  logic                  out_vld_q;
  logic [CountWidth-1:0] out_cnt_q;

  logic [CountWidth-1:0] count_mem [MAX_VALUE];

  logic [XW-1:0]         upper_x, max_x, bound_x, step_x, val_x;
  logic                  rd_ok, keep, rd_en, wr_en, out_free, accept;
  logic [CountWidth-1:0] r_m, nv, sum3_mod;
  logic [31:0]           sum3;
  logic [CountWidth:0]   acc_sum;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  // effective bound, saturated at the store depth
  always_comb begin
    upper_x = XW'(upper_q);
    max_x   = XW'(MAX_VALUE);
    bound_x = (upper_x > max_x) ? max_x : upper_x;
  end

  // window: lo = old[v-1], mid = old[v], r_m = old[v+1] for value v = step-2
  always_comb begin
    step_x = XW'(step_q);
    val_x  = step_x - XW'(2);
    rd_ok  = (step_x >= XW'(2)) && (step_x <= bound_x + XW'(1));
    r_m    = rd_ok ? rd_q : '0;
  end

  // shared three-term modular adder
  always_comb begin
    sum3 = {2'b00, lo_q} + {2'b00, mid_q} + {2'b00, r_m};
    if (sum3 >= Mod2) begin
      sum3_mod = CountWidth'(sum3 - Mod2);
    end else if (sum3 >= Mod1) begin
      sum3_mod = CountWidth'(sum3 - Mod1);
    end else begin
      sum3_mod = CountWidth'(sum3);
    end
  end

  // new count for value v: cleared above the bound or off a fixed value, one at a sequence start
  always_comb begin
    keep = (val_x <= bound_x) &&
           ((fixed_q == '0) || (XW'(fixed_q) == val_x));
    if (!keep) begin
      nv = '0;
    end else if (start_q) begin
      nv = CountWidth'(1);
    end else begin
      nv = sum3_mod;
    end
  end

  // modular accumulator for the final sum
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, nv_q};
    if (!nv_vld_q) begin
      acc_d = acc_q;
    end else if (acc_sum >= {1'b0, Modulus}) begin
      acc_d = CountWidth'(acc_sum - {1'b0, Modulus});
    end else begin
      acc_d = CountWidth'(acc_sum);
    end
  end

  // memory port enables
  assign rd_en = (state_q == StRun) && (step_x <= max_x);
  assign wr_en = (state_q == StRun) && (step_x >= XW'(3));

  // count memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      count_mem[AW'(step_q - CW'(3))] <= nv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= count_mem[AW'(step_q - CW'(1))];
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          step_d  = CW'(1);
        end
      end
      StRun: begin
        step_d = step_q + CW'(1);
        if (step_x == max_x + XW'(2)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (!last_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      upper_q   <= UpperReset;
      start_q   <= 1'b1;
      nv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      nv_vld_q <= wr_en;
      if (cfg_we_i) begin
        upper_q <= cfg_wdata_i;
      end
      if ((state_q == StFinish) && (!last_q || out_free)) begin
        start_q <= last_q;
      end
      if ((state_q == StFinish) && last_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fixed_q <= in_i.position_value;
      last_q  <= in_i.is_last;
      lo_q    <= '0;
      mid_q   <= '0;
      acc_q   <= '0;
    end else begin
      acc_q <= acc_d;
      if (state_q == StRun) begin
        lo_q  <= mid_q;
        mid_q <= r_m;
      end
    end
    if (wr_en) begin
      nv_q <= nv;
    end
    if ((state_q == StFinish) && last_q && out_free) begin
      out_cnt_q <= acc_q;
    end
  end

  assign in_i.ready           = (state_q == StIdle);
  assign out_o.valid          = out_vld_q;
  assign out_o.sequence_count = out_cnt_q;

endmodule

[tb/bounded_step_sequence_counter_tb.sv]
// self-checking testbench for the bounded step sequence counter
`timescale 1ns / 1ps

module bounded_step_sequence_counter_tb;
  import bssc_pkg::*;

  localparam int unsigned MaxValue    = DefaultMaxValue;
  // idle wait covering one request's pass through the block, with margin
  localparam int unsigned DrainCycles = MaxValue + 16;
  localparam logic [ValueWidth-1:0] FreeValue = '0;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ValueWidth-1:0] value_t;

  typedef enum logic {
    RowPosition,
    RowBound
  } row_kind_e;

  typedef enum int unsigned {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // directed row: a bound write or a position, with an optional typed count
  typedef struct packed {
    row_kind_e   kind;
    value_t      value;
    logic        is_last;
    logic        typed;
    count_t      total;
  } directed_row_t;

  localparam int unsigned NumRows = 28;
  localparam directed_row_t DirectedRows [NumRows] = '{
    // bound 128 after reset: one free position gives the bound
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd128},
    // 1, any, 128 cannot connect
    '{RowPosition, 8'd1,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd128, 1'b1, 1'b1, 30'd0},
    // fixed value above the bound
    '{RowPosition, 8'd255, 1'b1, 1'b1, 30'd0},
    '{RowPosition, 8'd128, 1'b1, 1'b1, 30'd1},
    // smallest bound
    '{RowBound,    8'd1,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd1},
    // zero bound allows no value
    '{RowBound,    8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd0},
    // bound above the store depth saturates
    '{RowBound,    8'd255, 1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd128},
    // bound 2: every sequence of ones and twos is valid
    '{RowBound,    8'd2,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd8},
    '{RowPosition, 8'd3,   1'b1, 1'b1, 30'd0},
    // bound raised in the middle of a sequence
    '{RowPosition, 8'd2,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowBound,    8'd5,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b0, 30'd0},
    // an out-of-range fixed value in the middle kills the sequence
    '{RowBound,    8'd128, 1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd129, 1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd0},
    // fixed value first, then one free position
    '{RowPosition, 8'd64,  1'b0, 1'b0, 30'd0},
    '{RowPosition, 8'd0,   1'b1, 1'b1, 30'd3}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  value_t cfg_wdata_i;

  bssc_in_if  req_if ();
  bssc_out_if res_if ();

  bounded_step_sequence_counter #(
    .MAX_VALUE (MaxValue)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  // predictor state
  count_t     value_counts [MaxValue+2];
  bit         at_start = 1'b1;
  value_t     bound_reg = UpperReset;

  count_t     pending_counts [$];
  idle_mode_e idle_mode = IdleNone;
  int unsigned mismatches;
  int unsigned positions_sent;
  int unsigned counts_checked;
  int unsigned bound_writes;

  // clock
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("bounded_step_sequence_counter regression: fail");
    $finish;
  end

  // advances the per-value counts by one position and sums them for a last one
  task automatic predict_sequence_count(input value_t pos, input logic is_last,
                                        output bit has_total, output count_t total);
    count_t      next_counts [MaxValue+2];
    logic [63:0] acc;
    int unsigned limit;

    limit = (bound_reg > MaxValue) ? MaxValue : bound_reg;
    for (int j = 0; j < MaxValue + 2; j++) begin
      next_counts[j] = '0;
    end
    for (int j = 1; j <= limit; j++) begin
      if (at_start) begin
        next_counts[j] = count_t'(1);
      end else begin
        acc = 64'(value_counts[j-1]) + 64'(value_counts[j]);
        if (j + 1 <= limit) begin
          acc += 64'(value_counts[j+1]);
        end
        next_counts[j] = count_t'(acc % 64'(Modulus));
      end
    end
    // a fixed position keeps only its own count
    if (pos != FreeValue) begin
      for (int j = 1; j <= MaxValue; j++) begin
        if (j != pos) next_counts[j] = '0;
      end
    end
    value_counts = next_counts;
    value_counts[0] = '0;
    value_counts[MaxValue+1] = '0;

    has_total = is_last;
    total = '0;
    if (is_last) begin
      acc = '0;
      for (int j = 1; j <= limit; j++) begin
        acc = (acc + 64'(value_counts[j])) % 64'(Modulus);
      end
      total = count_t'(acc);
    end
    at_start = is_last;
  endtask

  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IdleSender: return 66;
      IdleBoth:   return 28;
      default:    return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IdleReceiver: return 66;
      IdleBoth:     return 28;
      default:      return 0;
    endcase
  endfunction

  // drives one position request; entered and left at a falling edge
  task automatic send_position(input value_t pos, input logic is_last,
                               input logic typed, input count_t typed_total);
    bit     has_total;
    count_t total;

    while ($urandom_range(99) < sender_idle_pct()) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.position_value <= pos;
    req_if.is_last        <= is_last;
    do @(posedge clk_i); while (!req_if.ready);
    positions_sent++;
    predict_sequence_count(pos, is_last, has_total, total);
    if (has_total) begin
      pending_counts.push_back(typed ? typed_total : total);
    end
    @(negedge clk_i);
  endtask

  // writes the bound once the block has gone idle
  task automatic write_bound(input value_t value);
    req_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    bound_reg  = value;
    bound_writes++;
  endtask

  // one random sequence: free positions and a walk of neighbors, some noise
  task automatic send_random_sequence(output int unsigned length);
    int unsigned limit;
    int unsigned walk;
    int unsigned pick;
    value_t      pos;

    pick = $urandom_range(99);
    if (pick < 80)      length = $urandom_range(1, 12);
    else if (pick < 95) length = $urandom_range(13, 40);
    else                length = $urandom_range(41, 60);
    limit = (bound_reg > MaxValue) ? MaxValue : bound_reg;
    if (limit == 0) limit = 1;
    walk = $urandom_range(1, limit);
    for (int unsigned k = 0; k < length; k++) begin
      pick = $urandom_range(99);
      if (walk > 1 && $urandom_range(2) == 0) walk--;
      else if (walk < limit && $urandom_range(1) == 0) walk++;
      if (pick < 50)      pos = FreeValue;
      else if (pick < 88) pos = value_t'(walk);
      else if (pick < 95) pos = value_t'($urandom_range(1, MaxValue));
      else                pos = value_t'($urandom_range(0, 255));
      send_position(pos, k == length - 1, 1'b0, '0);
    end
  endtask

  // result readiness, changed at the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // result check against the oldest expected count
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected sequence_count, expected none, got %0d",
                 $time, res_if.sequence_count);
        mismatches++;
      end else begin
        if (res_if.sequence_count !== pending_counts[0]) begin
          $display("%0t: sequence_count mismatch, expected %0d, got %0d",
                   $time, pending_counts[0], res_if.sequence_count);
          mismatches++;
        end
        void'(pending_counts.pop_front());
        counts_checked++;
      end
    end
  end

  // main sequence
  initial begin
    value_t      phase_bounds [11];
    int unsigned phase_items;
    int unsigned seq_len;
    int unsigned sequences;

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    req_if.valid          = 1'b0;
    req_if.position_value = '0;
    req_if.is_last        = 1'b0;
    sequences             = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, no idling
    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].kind == RowBound) begin
        write_bound(DirectedRows[i].value);
      end else begin
        send_position(DirectedRows[i].value, DirectedRows[i].is_last,
                      DirectedRows[i].typed, DirectedRows[i].total);
      end
    end

    // random phases, each with its own bound and idling mode
    phase_bounds = '{8'd128, 8'd1, 8'd2, value_t'($urandom_range(3, 128)), 8'd255,
                     8'd0, 8'd127, value_t'($urandom_range(1, 128)), 8'd200,
                     8'd64, 8'd128};
    for (int p = 0; p < 11; p++) begin
      write_bound(phase_bounds[p]);
      idle_mode = idle_mode_e'(p % 4);
      phase_items = 0;
      while (phase_items < 36) begin
        send_random_sequence(seq_len);
        phase_items += seq_len;
        sequences++;
      end
    end
    req_if.valid <= 1'b0;

    // drain
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d positions in %0d random sequences plus the directed table",
             positions_sent, sequences);
    $display("checked %0d sequence counts over %0d bound settings",
             counts_checked, bound_writes);
    if (mismatches == 0) begin
      $display("bounded_step_sequence_counter regression: pass");
    end else begin
      $display("bounded_step_sequence_counter regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/bssc_pkg.sv
src/bssc_in_if.sv
src/bssc_out_if.sv
src/bounded_step_sequence_counter.sv
tb/bounded_step_sequence_counter_tb.sv
